// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/b64x_pkg.sv -----
// shared types and constants of the base64 xor decoder
`default_nettype none

package b64x_pkg;

	// entry queue between the decoder and the key stage
	localparam int QDEPTH   = 8;
	localparam int QAW      = $clog2(QDEPTH);
	localparam int QCW      = $clog2(QDEPTH + 1);
	localparam int Q_MAXPUSH = 3;
	localparam int Q_ROOM_MAX = QDEPTH - Q_MAXPUSH;

	localparam logic [7:0] PAD_CHAR = 8'h3d;

	typedef enum logic [1:0] {
		FUNC_KEY   = 2'd0,
		FUNC_CHAR  = 2'd1,
		FUNC_CLEAR = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ENT_KEY_APPEND = 2'd0,
		ENT_KEY_CLEAR  = 2'd1,
		ENT_RESULT     = 2'd2
	} ent_kind_t;

	typedef struct packed {
		ent_kind_t  kind;
		logic [7:0] data;
		logic       byte_valid;
		logic       run_end;
		logic       message_end;
	} ent_t;

	typedef struct packed {
		logic room;
		logic empty;
	} qstat_t;

endpackage

`default_nettype wire

// ----- rtl/b64x_decode.sv -----
// input register and base64 sextet decoder, emits up to three queue entries
`default_nettype none

module b64x_decode
	import b64x_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  in_func,
	input  wire logic [7:0]  in_key_byte,
	input  wire logic [7:0]  in_code_char,
	input  wire logic        in_last,
	input  wire qstat_t      qstat,
	output logic [1:0]       push_n,
	output ent_t             push_ent [Q_MAXPUSH]
);

	logic        valid_s1;
	func_t       func_s1;
	logic [7:0]  kb_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;

	logic [17:0] buf_q, buf_n;
	logic [1:0]  cnt_q, cnt_n;
	logic        pad_q, pad_n;

	logic        advance;
	logic [1:0]  n;
	logic [6:0]  sx;
	logic [23:0] word;

	// {ok, value} of a base64 alphabet character
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] r;
		r = 7'd0;
		if (c >= 8'h41 && c <= 8'h5a)
			r = {1'b1, 6'(c - 8'h41)};
		else if (c >= 8'h61 && c <= 8'h7a)
			r = {1'b1, 6'(c - 8'h61 + 8'd26)};
		else if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 6'(c - 8'h30 + 8'd52)};
		else if (c == 8'h2b)
			r = {1'b1, 6'd62};
		else if (c == 8'h2f)
			r = {1'b1, 6'd63};
		return r;
	endfunction

	assign advance  = valid_s1 && qstat.room;
	assign in_ready = !valid_s1 || qstat.room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			buf_q    <= '0;
			cnt_q    <= '0;
			pad_q    <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance) begin
				buf_q <= buf_n;
				cnt_q <= cnt_n;
				pad_q <= pad_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			func_s1 <= func_t'(in_func);
			kb_s1   <= in_key_byte;
			ch_s1   <= in_code_char;
			last_s1 <= in_last;
		end
	end

	assign sx   = sextet_of(ch_s1);
	assign word = {buf_q, sx[5:0]};

	always_comb begin
		buf_n = buf_q;
		cnt_n = cnt_q;
		pad_n = pad_q;
		n     = 2'd0;
		for (int i = 0; i < Q_MAXPUSH; i++) begin
			push_ent[i].kind        = ENT_RESULT;
			push_ent[i].data        = 8'd0;
			push_ent[i].byte_valid  = 1'b0;
			push_ent[i].run_end     = 1'b0;
			push_ent[i].message_end = 1'b0;
		end
		unique case (func_s1)
			FUNC_KEY: begin
				push_ent[0].kind = ENT_KEY_APPEND;
				push_ent[0].data = kb_s1;
				n = 2'd1;
			end
			FUNC_CLEAR: begin
				push_ent[0].kind = ENT_KEY_CLEAR;
				n     = 2'd1;
				buf_n = '0;
				cnt_n = '0;
				pad_n = 1'b0;
			end
			FUNC_CHAR: begin
				if (!pad_q) begin
					if (ch_s1 == PAD_CHAR) begin
						pad_n = 1'b1;
					end else if (sx[6]) begin
						if (cnt_q == 2'd3) begin
							push_ent[0].data = word[23:16];
							push_ent[1].data = word[15:8];
							push_ent[2].data = word[7:0];
							for (int i = 0; i < Q_MAXPUSH; i++)
								push_ent[i].byte_valid = 1'b1;
							n     = 2'd3;
							buf_n = '0;
							cnt_n = '0;
						end else begin
							buf_n = {buf_q[11:0], sx[5:0]};
							cnt_n = cnt_q + 2'd1;
						end
					end
				end
				if (last_s1) begin
					// flush of a partial group, a single sextet gives nothing
					if (cnt_n == 2'd2) begin
						push_ent[0].data       = buf_n[11:4];
						push_ent[0].byte_valid = 1'b1;
						n = 2'd1;
					end else if (cnt_n == 2'd3) begin
						push_ent[0].data       = buf_n[17:10];
						push_ent[1].data       = buf_n[9:2];
						push_ent[0].byte_valid = 1'b1;
						push_ent[1].byte_valid = 1'b1;
						n = 2'd2;
					end
					// bare end marker
					if (n == 2'd0)
						n = 2'd1;
					buf_n = '0;
					cnt_n = '0;
					pad_n = 1'b0;
				end
				for (int i = 0; i < Q_MAXPUSH; i++) begin
					if (2'(i) + 2'd1 == n) begin
						push_ent[i].run_end     = 1'b1;
						push_ent[i].message_end = last_s1;
					end
				end
			end
			default: begin
				n = 2'd0;
			end
		endcase
	end

	assign push_n = advance ? n : 2'd0;

endmodule

`default_nettype wire

// ----- rtl/b64x_queue.sv -----
// entry queue, up to three pushes and one pop per cycle
`default_nettype none

module b64x_queue
	import b64x_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic [1:0] push_n,
	input  wire ent_t  push_ent [Q_MAXPUSH],
	input  wire logic  pop,
	output ent_t       head,
	output qstat_t     qstat
);

	ent_t             entries_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < Q_MAXPUSH; i++) begin
			if (2'(i) < push_n)
				entries_q[wr_ptr_q + QAW'(i)] <= push_ent[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAW'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			count_q <= count_q + QCW'(push_n) - QCW'(pop);
		end
	end

	assign head        = entries_q[rd_ptr_q];
	assign qstat.empty = (count_q == '0);
	// room check ignores the pop so input ready has no combinational path from the output side
	assign qstat.room  = (count_q <= QCW'(Q_ROOM_MAX));

endmodule

`default_nettype wire

// ----- rtl/b64x_key.sv -----
// key store, repeating key position and output register stage
`default_nettype none

module b64x_key
	import b64x_pkg::*;
#(
	parameter int KEY_DEPTH = 64
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire ent_t  head,
	input  wire qstat_t qstat,
	output logic       pop,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] out_byte,
	output logic       out_byte_valid,
	output logic       out_run_end,
	output logic       out_message_end
);

	localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
	localparam int KLW = $clog2(KEY_DEPTH + 1);

	logic [7:0]     key_mem [KEY_DEPTH];
	logic [KLW-1:0] klen_q;
	logic [KAW-1:0] kpos_q;

	logic       valid_s2;
	logic [7:0] byte_s2;
	logic [7:0] kbyte_s2;
	logic       usekey_s2;
	logic       bvalid_s2;
	logic       run_end_s2;
	logic       msg_end_s2;

	logic is_result;
	logic take_result;
	logic wr_en;
	logic rd_en;
	logic wrap;

	assign is_result   = (head.kind == ENT_RESULT);
	assign pop         = !qstat.empty && (!is_result || !valid_s2 || out_ready);
	assign take_result = pop && is_result;
	assign wr_en       = pop && (head.kind == ENT_KEY_APPEND) && (klen_q < KLW'(KEY_DEPTH));
	assign rd_en       = take_result && head.byte_valid && (klen_q != '0);
	assign wrap        = (KLW'(kpos_q) + KLW'(1)) >= klen_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			key_mem[klen_q[KAW-1:0]] <= head.data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			kbyte_s2 <= key_mem[kpos_q];
		if (take_result) begin
			byte_s2    <= head.data;
			usekey_s2  <= rd_en;
			bvalid_s2  <= head.byte_valid;
			run_end_s2 <= head.run_end;
			msg_end_s2 <= head.message_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			klen_q   <= '0;
			kpos_q   <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (take_result)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;

			if (wr_en)
				klen_q <= klen_q + KLW'(1);

			if (pop) begin
				case (head.kind)
					ENT_KEY_CLEAR: begin
						klen_q <= '0;
						kpos_q <= '0;
					end
					ENT_RESULT: begin
						// message end restarts the key at its first byte
						if (head.message_end)
							kpos_q <= '0;
						else if (rd_en)
							kpos_q <= wrap ? '0 : kpos_q + KAW'(1);
					end
					default: begin
						kpos_q <= kpos_q;
					end
				endcase
			end
		end
	end

	assign out_valid       = valid_s2;
	assign out_byte        = byte_s2 ^ (usekey_s2 ? kbyte_s2 : 8'd0);
	assign out_byte_valid  = bvalid_s2;
	assign out_run_end     = run_end_s2;
	assign out_message_end = msg_end_s2;

endmodule

`default_nettype wire

// ----- rtl/base64_xor_decrypt.sv -----
// Base64 decoder with repeating-key xor, stream in and stream out.
// Slave side: one transaction per item. tuser carries the function (append key
// byte, encoded character, clear key and message state), tdata carries the key
// byte and the character, tlast marks the final character of a message.
// Master side: one transaction per decoded byte or bare end marker. tdata is the
// plain byte, tuser flags byte valid and message end, tlast closes the results
// of one input item. A full group of four characters gives three bytes, the
// message end flushes the tail.
// Throughput: one item per cycle while the queue has room; results leave at one
// per cycle from the key stage while the receiver is ready, its single key store
// read port setting that figure. An eight-entry queue between decoder and key
// stage absorbs the three-byte bursts; input ready drops while more than five
// entries wait and an item sits in the input register.
// When the receiver stalls, the output holds and the queue fills, then input
// ready falls. Reset clears the key length, key position, decoder state and
// queue; key store contents are not cleared.
`default_nettype none

module base64_xor_decrypt
	import b64x_pkg::*;
#(
	parameter int KEY_DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // key_byte[7:0], code_char[15:8]
	input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // plain_byte[7:0]
	output logic [1:0]       m_axis_tuser,  // byte_valid[0], message_end[1]
	output logic             m_axis_tlast
);

	logic [1:0] push_n;
	ent_t       push_ent [Q_MAXPUSH];
	ent_t       head;
	qstat_t     qstat;
	logic       pop;
	logic       byte_valid;
	logic       message_end;

	b64x_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.in_func      (s_axis_tuser),
		.in_key_byte  (s_axis_tdata[7:0]),
		.in_code_char (s_axis_tdata[15:8]),
		.in_last      (s_axis_tlast),
		.qstat        (qstat),
		.push_n       (push_n),
		.push_ent     (push_ent)
	);

	b64x_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (push_n),
		.push_ent (push_ent),
		.pop      (pop),
		.head     (head),
		.qstat    (qstat)
	);

	b64x_key #(
		.KEY_DEPTH (KEY_DEPTH)
	) u_key (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.qstat           (qstat),
		.pop             (pop),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_byte        (m_axis_tdata),
		.out_byte_valid  (byte_valid),
		.out_run_end     (m_axis_tlast),
		.out_message_end (message_end)
	);

	assign m_axis_tuser = {message_end, byte_valid};

endmodule

`default_nettype wire

// ----- rtl/b64x_checker.sv -----
// port-level checks of the base64 xor decoder and their bind
`default_nettype none
`include "assert_macros.svh"

module b64x_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic [1:0]  m_axis_tuser,
	input wire logic        m_axis_tlast
);

	logic        out_stall;
	logic [10:0] out_word;
	assign out_stall = m_axis_tvalid && !m_axis_tready;
	assign out_word  = {m_axis_tdata, m_axis_tuser, m_axis_tlast};

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_stall, m_axis_tvalid && $stable(out_word))

	// message end is always the last result of its item
	`ASSERT_NOW(a_msg_end_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)

	// a bare marker only closes a message and carries a zero byte
	`ASSERT_NOW(a_marker, clk, arst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1] && (m_axis_tdata == 8'd0))

	// nothing comes out in the cycle after reset releases
	`ASSERT_NEXT(a_no_early_out, clk, arst_n, $rose(arst_n), !m_axis_tvalid)

	// the empty pipeline takes input right after reset
	`ASSERT_NEXT(a_ready_after_reset, clk, arst_n, $rose(arst_n), s_axis_tready)

endmodule

bind base64_xor_decrypt b64x_checker u_b64x_checker (.*);

`default_nettype wire
